// ===== hdl/vse_pkg.sv =====
package vse_pkg;

    // Build-time defaults and fixed field widths
    localparam int MAX_VALUES_DEF = 64;
    localparam int VALUE_W        = 32;
    localparam int RESULT_W       = 64;
    localparam int COUNT_W        = 7;
    localparam int ROOT_W         = 32;

    // stat_mode codes
    localparam logic MODE_SAMPLE_VAR = 1'b1;
    localparam logic STAT_MODE_RST   = MODE_SAMPLE_VAR;

    // Back-end sequencer states
    typedef enum logic [2:0] {
        BK_IDLE,
        BK_MEAN,
        BK_PASS,
        BK_VDIV,
        BK_ROOT
    } t_back_state;

    // One finished result, back end to top level
    typedef struct packed {
        logic                strobe;
        logic [RESULT_W-1:0] value;
        logic                ovf;
        logic [COUNT_W-1:0]  count;
    } t_result;

endpackage

// ===== hdl/vse_store.sv =====
module vse_store #(
    parameter int MAX_VALUES = vse_pkg::MAX_VALUES_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_wr_en,
    input  logic [$clog2(MAX_VALUES)-1:0]      i_wr_addr,
    input  logic [vse_pkg::VALUE_W-1:0]        i_wr_data,
    input  logic                               i_rd_en,
    input  logic [$clog2(MAX_VALUES)-1:0]      i_rd_addr,
    output logic [vse_pkg::VALUE_W-1:0]        o_rd_data
);
    import vse_pkg::*;

    logic [VALUE_W-1:0] r_mem [MAX_VALUES];
    logic [VALUE_W-1:0] r_rd_data;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== hdl/vse_front.sv =====
module vse_front #(
    parameter int  MAX_VALUES = vse_pkg::MAX_VALUES_DEF,
    localparam int CNT_W      = $clog2(MAX_VALUES + 1),
    localparam int IDX_W      = $clog2(MAX_VALUES),
    localparam int SUM_W      = vse_pkg::VALUE_W + $clog2(MAX_VALUES)
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_start,
    output logic                               o_busy,
    input  logic signed [vse_pkg::VALUE_W-1:0] i_sample_value,
    input  logic                               i_last_value,
    input  logic [CNT_W-1:0]                   i_free,
    output logic                               o_wr_en,
    output logic [IDX_W-1:0]                   o_wr_addr,
    output logic [vse_pkg::VALUE_W-1:0]        o_wr_data,
    output logic                               o_job_valid,
    input  logic                               i_job_pop,
    output logic [CNT_W-1:0]                   o_job_n,
    output logic signed [SUM_W-1:0]            o_job_sum,
    output logic                               o_job_drop
);
    import vse_pkg::*;

    logic [CNT_W-1:0]        r_count, n_count;
    logic signed [SUM_W-1:0] r_sum, n_sum;
    logic                    r_drop, n_drop;
    logic                    r_job_valid, n_job_valid;
    logic [CNT_W-1:0]        r_job_n;
    logic signed [SUM_W-1:0] r_job_sum;
    logic                    r_job_drop;

    logic                    w_full;
    logic                    w_can_take;
    logic                    w_accept;
    logic signed [SUM_W-1:0] w_ext;
    logic [CNT_W-1:0]        w_cnt_inc;
    logic signed [SUM_W-1:0] w_sum_inc;
    logic                    w_drop_inc;

    // Take an item unless a set waits in the queue or the back end still
    // needs the entry this item would overwrite; a full store only drops
    assign w_full     = (r_count == CNT_W'(MAX_VALUES));
    assign w_can_take = !r_job_valid && (w_full || (r_count < i_free));
    assign w_accept   = i_start && w_can_take;
    assign o_busy     = !w_can_take;

    // Running count, sum and drop mark after this item
    assign w_ext      = SUM_W'(i_sample_value);
    assign w_cnt_inc  = w_full ? r_count : r_count + 1'b1;
    assign w_sum_inc  = w_full ? r_sum : r_sum + w_ext;
    assign w_drop_inc = r_drop | w_full;

    // Next state
    always_comb begin
        n_count     = r_count;
        n_sum       = r_sum;
        n_drop      = r_drop;
        n_job_valid = r_job_valid && !i_job_pop;
        if (w_accept) begin
            if (i_last_value) begin
                n_count     = '0;
                n_sum       = '0;
                n_drop      = 1'b0;
                n_job_valid = 1'b1;
            end else begin
                n_count = w_cnt_inc;
                n_sum   = w_sum_inc;
                n_drop  = w_drop_inc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_sum       <= '0;
            r_drop      <= 1'b0;
            r_job_valid <= 1'b0;
        end else begin
            r_count     <= n_count;
            r_sum       <= n_sum;
            r_drop      <= n_drop;
            r_job_valid <= n_job_valid;
        end
    end

    // One-entry job queue toward the back end
    always_ff @(posedge i_clk) begin
        if (w_accept && i_last_value) begin
            r_job_n    <= w_cnt_inc;
            r_job_sum  <= w_sum_inc;
            r_job_drop <= w_drop_inc;
        end
    end

    // Store write
    assign o_wr_en   = w_accept && !w_full;
    assign o_wr_addr = r_count[IDX_W-1:0];
    assign o_wr_data = i_sample_value;

    assign o_job_valid = r_job_valid;
    assign o_job_n     = r_job_n;
    assign o_job_sum   = r_job_sum;
    assign o_job_drop  = r_job_drop;

endmodule

// ===== hdl/vse_div.sv =====
module vse_div #(
    parameter int  DVD_W  = 70,
    parameter int  DVS_W  = 7,
    localparam int STEP_W = $clog2(DVD_W)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DVD_W-1:0] i_dividend,
    input  logic [DVS_W-1:0] i_divisor,
    output logic             o_done,
    output logic [DVD_W-1:0] o_quotient
);
    import vse_pkg::*;

    logic              r_busy;
    logic              r_done;
    logic [STEP_W-1:0] r_step;
    logic [DVD_W-1:0]  r_dq;
    logic [DVS_W-1:0]  r_rem;
    logic [DVS_W-1:0]  r_dvs;

    logic [DVS_W:0]    w_trial;
    logic              w_ge;
    logic [DVS_W-1:0]  w_rem_nx;

    // One restoring step: shift in the next dividend bit, subtract if it fits
    always_comb begin
        w_trial  = {r_rem, r_dq[DVD_W-1]};
        w_ge     = (w_trial >= {1'b0, r_dvs});
        w_rem_nx = w_ge ? DVS_W'(w_trial - {1'b0, r_dvs}) : w_trial[DVS_W-1:0];
    end

    // Step control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + 1'b1;
                if (r_step == STEP_W'(DVD_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Quotient bits shift in where the dividend shifts out
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dq  <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_rem <= w_rem_nx;
            r_dq  <= {r_dq[DVD_W-2:0], w_ge};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_dq;

endmodule

// ===== hdl/vse_sqrt.sv =====
module vse_sqrt (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [2*vse_pkg::ROOT_W-1:0]  i_radicand,
    output logic                          o_done,
    output logic [vse_pkg::ROOT_W-1:0]    o_root
);
    import vse_pkg::*;

    localparam int RAD_W  = 2 * ROOT_W;
    localparam int REM_W  = ROOT_W + 2;
    localparam int STEP_W = $clog2(ROOT_W);

    logic              r_busy;
    logic              r_done;
    logic [STEP_W-1:0] r_step;
    logic [RAD_W-1:0]  r_x;
    logic [REM_W-1:0]  r_rem;
    logic [ROOT_W-1:0] r_root;

    logic [REM_W+1:0]  w_trial;
    logic [REM_W+1:0]  w_test;
    logic              w_ge;
    logic [REM_W-1:0]  w_rem_nx;

    // One root digit per step: bring down two bits, test root*4+1
    always_comb begin
        w_trial  = {r_rem, r_x[RAD_W-1 -: 2]};
        w_test   = {2'b00, r_root, 2'b01};
        w_ge     = (w_trial >= w_test);
        w_rem_nx = w_ge ? REM_W'(w_trial - w_test) : REM_W'(w_trial);
    end

    // Step control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + 1'b1;
                if (r_step == STEP_W'(ROOT_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x    <= i_radicand;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_x    <= {r_x[RAD_W-3:0], 2'b00};
            r_rem  <= w_rem_nx;
            r_root <= {r_root[ROOT_W-2:0], w_ge};
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule

// ===== hdl/vse_back.sv =====
module vse_back #(
    parameter int  MAX_VALUES = vse_pkg::MAX_VALUES_DEF,
    localparam int CNT_W      = $clog2(MAX_VALUES + 1),
    localparam int IDX_W      = $clog2(MAX_VALUES),
    localparam int SUM_W      = vse_pkg::VALUE_W + $clog2(MAX_VALUES),
    localparam int ACC_W      = vse_pkg::RESULT_W + $clog2(MAX_VALUES)
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_stat_mode,
    input  logic                        i_job_valid,
    output logic                        o_job_pop,
    input  logic [CNT_W-1:0]            i_job_n,
    input  logic signed [SUM_W-1:0]     i_job_sum,
    input  logic                        i_job_drop,
    output logic [CNT_W-1:0]            o_free,
    output logic                        o_rd_en,
    output logic [IDX_W-1:0]            o_rd_addr,
    input  logic [vse_pkg::VALUE_W-1:0] i_rd_data,
    output vse_pkg::t_result            o_res
);
    import vse_pkg::*;

    t_back_state           r_state, n_state;
    logic [CNT_W-1:0]      r_n;
    logic                  r_neg;
    logic                  r_drop;
    logic signed [VALUE_W-1:0] r_mean;
    logic [CNT_W-1:0]      r_rd_idx;
    logic                  r_v1, r_v2, r_v3;
    logic [VALUE_W-1:0]    r_mag;
    logic [RESULT_W-1:0]   r_sq;
    logic [ACC_W-1:0]      r_acc;
    logic                  r_res_strobe;
    logic [RESULT_W-1:0]   r_res_value;
    logic                  r_res_ovf;
    logic [COUNT_W-1:0]    r_res_count;

    logic                  w_div_start;
    logic [ACC_W-1:0]      w_div_dividend;
    logic [CNT_W-1:0]      w_div_divisor;
    logic                  w_div_done;
    logic [ACC_W-1:0]      w_div_q;
    logic                  w_sat;
    logic                  w_rt_start;
    logic                  w_rt_done;
    logic [ROOT_W-1:0]     w_rt_root;
    logic [SUM_W-1:0]      w_sum_abs;
    logic                  w_issue;
    logic                  w_pass_end;
    logic                  w_emit;
    logic [RESULT_W-1:0]   w_emit_value;
    logic                  w_emit_ovf;
    logic [CNT_W-1:0]      w_emit_n;
    logic signed [VALUE_W:0] w_diff;
    logic [VALUE_W-1:0]    w_mag;

    // Shared restoring divider: mean first, then the final quotient
    vse_div #(
        .DVD_W (ACC_W),
        .DVS_W (CNT_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_div_dividend),
        .i_divisor  (w_div_divisor),
        .o_done     (w_div_done),
        .o_quotient (w_div_q)
    );

    vse_sqrt u_sqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_rt_start),
        .i_radicand (w_div_q[RESULT_W-1:0]),
        .o_done     (w_rt_done),
        .o_root     (w_rt_root)
    );

    assign w_sum_abs  = i_job_sum[SUM_W-1] ? SUM_W'(-i_job_sum) : SUM_W'(i_job_sum);
    assign w_sat      = |w_div_q[ACC_W-1:RESULT_W];
    assign w_issue    = (r_state == BK_PASS) && (r_rd_idx < r_n);
    assign w_pass_end = (r_state == BK_PASS) && (r_rd_idx == r_n) && !r_v1 && !r_v2 && !r_v3;

    // Sequencer: next state, unit starts and result capture
    always_comb begin
        n_state        = r_state;
        o_job_pop      = 1'b0;
        w_div_start    = 1'b0;
        w_div_dividend = ACC_W'(w_sum_abs);
        w_div_divisor  = i_job_n;
        w_rt_start     = 1'b0;
        w_emit         = 1'b0;
        w_emit_value   = '0;
        w_emit_ovf     = r_drop;
        w_emit_n       = r_n;
        case (r_state)
            BK_IDLE: begin
                if (i_job_valid) begin
                    o_job_pop = 1'b1;
                    if (i_job_n < CNT_W'(2)) begin
                        // a set of one value gives zero at once
                        w_emit     = 1'b1;
                        w_emit_ovf = i_job_drop;
                        w_emit_n   = i_job_n;
                    end else begin
                        w_div_start = 1'b1;
                        n_state     = BK_MEAN;
                    end
                end
            end
            BK_MEAN: begin
                if (w_div_done) begin
                    n_state = BK_PASS;
                end
            end
            BK_PASS: begin
                if (w_pass_end) begin
                    w_div_start    = 1'b1;
                    w_div_dividend = r_acc;
                    w_div_divisor  = (i_stat_mode == MODE_SAMPLE_VAR) ? r_n - 1'b1 : r_n;
                    n_state        = BK_VDIV;
                end
            end
            BK_VDIV: begin
                if (w_div_done) begin
                    if (w_sat) begin
                        w_emit       = 1'b1;
                        w_emit_value = '1;
                        w_emit_ovf   = 1'b1;
                        n_state      = BK_IDLE;
                    end else if (i_stat_mode == MODE_SAMPLE_VAR) begin
                        w_emit       = 1'b1;
                        w_emit_value = w_div_q[RESULT_W-1:0];
                        n_state      = BK_IDLE;
                    end else begin
                        w_rt_start = 1'b1;
                        n_state    = BK_ROOT;
                    end
                end
            end
            BK_ROOT: begin
                if (w_rt_done) begin
                    w_emit       = 1'b1;
                    w_emit_value = RESULT_W'(w_rt_root);
                    n_state      = BK_IDLE;
                end
            end
            default: begin
                n_state = BK_IDLE;
            end
        endcase
    end

    // Free entries: none in MEAN, below read idx in PASS, else all
    always_comb begin
        case (r_state)
            BK_MEAN: o_free = '0;
            BK_PASS: o_free = r_rd_idx;
            default: o_free = CNT_W'(MAX_VALUES);
        endcase
    end

    // Deviation magnitude from the stored value
    always_comb begin
        w_diff = $signed({i_rd_data[VALUE_W-1], i_rd_data})
               - $signed({r_mean[VALUE_W-1], r_mean});
        w_mag  = w_diff[VALUE_W] ? VALUE_W'(-w_diff) : w_diff[VALUE_W-1:0];
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= BK_IDLE;
            r_v1         <= 1'b0;
            r_v2         <= 1'b0;
            r_v3         <= 1'b0;
            r_res_strobe <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_v1         <= w_issue;
            r_v2         <= r_v1;
            r_v3         <= r_v2;
            r_res_strobe <= w_emit;
        end
    end

    // Job, mean and squared-deviation pipeline
    always_ff @(posedge i_clk) begin
        if (o_job_pop) begin
            r_n      <= i_job_n;
            r_neg    <= i_job_sum[SUM_W-1];
            r_drop   <= i_job_drop;
            r_acc    <= '0;
            r_rd_idx <= '0;
        end else begin
            if (w_issue) begin
                r_rd_idx <= r_rd_idx + 1'b1;
            end
            if (r_v3) begin
                r_acc <= r_acc + ACC_W'(r_sq);
            end
        end
        if ((r_state == BK_MEAN) && w_div_done) begin
            r_mean <= r_neg ? -w_div_q[VALUE_W-1:0] : w_div_q[VALUE_W-1:0];
        end
        if (r_v1) begin
            r_mag <= w_mag;
        end
        if (r_v2) begin
            r_sq <= r_mag * r_mag;
        end
        if (w_emit) begin
            r_res_value <= w_emit_value;
            r_res_ovf   <= w_emit_ovf;
            r_res_count <= COUNT_W'(w_emit_n);
        end
    end

    assign o_rd_en   = w_issue;
    assign o_rd_addr = r_rd_idx[IDX_W-1:0];

    assign o_res = '{strobe: r_res_strobe, value: r_res_value,
                     ovf: r_res_ovf, count: r_res_count};

endmodule

// ===== hdl/variance_stddev_engine_unit.sv =====
// Loading: values load one per cycle while busy is low; after the last value the result
//   strobe follows two runs of the shared one-bit-per-cycle divider, the N-entry read
//   pass and, in stddev mode, the root.
// Throughput: one set at a time in the back end; the next set loads as soon as the read
//   pass has passed the entry it writes. Results cannot be stalled: one cycle each.
// Reset: synchronous, active low; counts, queue and sequencer clear, stat_mode returns to 1.
module variance_stddev_engine_unit #(
    parameter int MAX_VALUES = vse_pkg::MAX_VALUES_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic signed [vse_pkg::VALUE_W-1:0]  i_sample_value,
    input  logic                                i_last_value,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic                                i_cfg_data,
    output logic                                o_result_strobe,
    output logic [vse_pkg::RESULT_W-1:0]        o_stat_result,
    output logic                                o_overflow_flag,
    output logic [vse_pkg::COUNT_W-1:0]         o_value_count
);
    import vse_pkg::*;

    localparam int CNT_W = $clog2(MAX_VALUES + 1);
    localparam int IDX_W = $clog2(MAX_VALUES);
    localparam int SUM_W = VALUE_W + $clog2(MAX_VALUES);

    logic                    r_stat_mode;
    logic                    w_wr_en;
    logic [IDX_W-1:0]        w_wr_addr;
    logic [VALUE_W-1:0]      w_wr_data;
    logic                    w_rd_en;
    logic [IDX_W-1:0]        w_rd_addr;
    logic [VALUE_W-1:0]      w_rd_data;
    logic [CNT_W-1:0]        w_free;
    logic                    w_job_valid;
    logic                    w_job_pop;
    logic [CNT_W-1:0]        w_job_n;
    logic signed [SUM_W-1:0] w_job_sum;
    logic                    w_job_drop;
    t_result                 w_res;

    // Mode register
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stat_mode <= STAT_MODE_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_stat_mode <= i_cfg_data;
        end
    end

    vse_front #(
        .MAX_VALUES (MAX_VALUES)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (start),
        .o_busy         (busy),
        .i_sample_value (i_sample_value),
        .i_last_value   (i_last_value),
        .i_free         (w_free),
        .o_wr_en        (w_wr_en),
        .o_wr_addr      (w_wr_addr),
        .o_wr_data      (w_wr_data),
        .o_job_valid    (w_job_valid),
        .i_job_pop      (w_job_pop),
        .o_job_n        (w_job_n),
        .o_job_sum      (w_job_sum),
        .o_job_drop     (w_job_drop)
    );

    vse_store #(
        .MAX_VALUES (MAX_VALUES)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    vse_back #(
        .MAX_VALUES (MAX_VALUES)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_stat_mode (r_stat_mode),
        .i_job_valid (w_job_valid),
        .o_job_pop   (w_job_pop),
        .i_job_n     (w_job_n),
        .i_job_sum   (w_job_sum),
        .i_job_drop  (w_job_drop),
        .o_free      (w_free),
        .o_rd_en     (w_rd_en),
        .o_rd_addr   (w_rd_addr),
        .i_rd_data   (w_rd_data),
        .o_res       (w_res)
    );

    assign o_result_strobe = w_res.strobe;
    assign o_stat_result   = w_res.value;
    assign o_overflow_flag = w_res.ovf;
    assign o_value_count   = w_res.count;

    // A store write never lands on an entry the read pass still needs
    a_wr_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_wr_en |-> (CNT_W'(w_wr_addr) < w_free))
        else $error("store write into an entry still in use");

    // No item is taken while a closed set waits in the queue
    a_no_take_queued: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> !w_job_valid)
        else $error("item accepted while a set is queued");

    // A pop empties the queue
    a_pop_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_job_pop |=> !w_job_valid)
        else $error("queue still full after pop");

    // An overflow without saturation only comes from a full store
    a_ovf_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_strobe && o_overflow_flag && (o_stat_result != '1))
        |-> (o_value_count == COUNT_W'(MAX_VALUES)))
        else $error("overflow flag without saturation or full store");

endmodule

// ===== tb/variance_stddev_engine_unit_test.sv =====
module variance_stddev_engine_unit_test;

    import vse_pkg::*;

    localparam int   CLK_PERIOD      = 4;
    localparam int   STORE_DEPTH     = MAX_VALUES_DEF;
    localparam int   SETTLE_CYCLES   = 300;
    localparam int   ITEMS_PER_PHASE = 250;
    localparam logic MODE_POP_STDDEV = !MODE_SAMPLE_VAR;

    // One input item: a value and its end-of-set mark
    typedef struct {
        logic signed [VALUE_W-1:0] value;
        logic                      last;
    } t_sample_item;

    // One predicted result
    typedef struct {
        logic [RESULT_W-1:0] stat;
        logic                ovf;
        logic [COUNT_W-1:0]  count;
    } t_stat_expect;

    logic                       i_clk = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       start = 1'b0;
    logic                       busy;
    logic signed [VALUE_W-1:0]  i_sample_value = '0;
    logic                       i_last_value = 1'b0;
    logic                       i_cfg_valid = 1'b0;
    logic                       o_cfg_ready;
    logic                       i_cfg_data = 1'b0;
    logic                       o_result_strobe;
    logic [RESULT_W-1:0]        o_stat_result;
    logic                       o_overflow_flag;
    logic [COUNT_W-1:0]         o_value_count;

    // Stimulus and predictions
    t_sample_item pending_items[$];
    t_stat_expect expected_stats[$];
    int           sender_idle_pct = 0;
    int           mismatch_count = 0;

    // Predictor copy of the block state
    logic signed [VALUE_W-1:0] held_values[STORE_DEPTH];
    int                        held_count = 0;
    longint                    held_sum = 0;
    logic                      held_dropped = 1'b0;
    logic                      predicted_mode = STAT_MODE_RST;

    variance_stddev_engine_unit dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_sample_value  (i_sample_value),
        .i_last_value    (i_last_value),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (i_cfg_data),
        .o_result_strobe (o_result_strobe),
        .o_stat_result   (o_stat_result),
        .o_overflow_flag (o_overflow_flag),
        .o_value_count   (o_value_count)
    );

    always #(CLK_PERIOD/2) i_clk = ~i_clk;

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t: %s", $time, msg);
        mismatch_count++;
    endtask

    // Floor square root, one result bit per step from the top
    function automatic logic [RESULT_W-1:0] floor_sqrt(input logic [RESULT_W-1:0] x);
        logic [RESULT_W-1:0] root;
        logic [RESULT_W-1:0] trial;
        root = '0;
        for (int b = ROOT_W - 1; b >= 0; b--) begin
            trial = root | (64'd1 << b);
            if (trial * trial <= x) root = trial;
        end
        return root;
    endfunction

    // Take one accepted item; on the last one of a set, queue the expected statistic
    function automatic void predict_item(input t_sample_item item);
        t_stat_expect        want;
        longint              set_mean;
        longint              dev;
        logic [RESULT_W-1:0] mag;
        logic [127:0]        sq_total;
        logic [RESULT_W-1:0] divisor;
        logic [RESULT_W-1:0] quot;
        logic                saturated;
        int                  n;

        if (held_count < STORE_DEPTH) begin
            held_values[held_count] = item.value;
            held_sum += longint'(item.value);
            held_count++;
        end else begin
            held_dropped = 1'b1;
        end
        if (!item.last) return;

        n = held_count;
        saturated = 1'b0;
        want.stat = '0;
        if (n >= 2) begin
            set_mean = held_sum / longint'(n);
            sq_total = '0;
            for (int i = 0; i < n; i++) begin
                dev = longint'(held_values[i]) - set_mean;
                mag = (dev < 0) ? -dev : dev;
                sq_total += 128'(mag) * 128'(mag);
            end
            divisor = (predicted_mode == MODE_SAMPLE_VAR) ? 64'(n - 1) : 64'(n);
            quot = '0;
            // quotient does not fit 64 bits
            if (sq_total[127:64] >= divisor) saturated = 1'b1;
            else quot = 64'(sq_total / 128'(divisor));
            if (saturated) want.stat = '1;
            else if (predicted_mode == MODE_SAMPLE_VAR) want.stat = quot;
            else want.stat = floor_sqrt(quot);
        end
        want.ovf = saturated | held_dropped;
        want.count = COUNT_W'(n);
        expected_stats = {expected_stats, want};

        held_count = 0;
        held_sum = 0;
        held_dropped = 1'b0;
    endfunction

    // Driver: present the oldest pending item, hold it until accepted
    always @(posedge i_clk) begin : drive_items
        t_sample_item item;
        logic         accepted;
        accepted = start && !busy;
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (accepted) begin
                item = pending_items.pop_front();
                predict_item(item);
            end
            if (start && !accepted) begin
                // held: inputs stay as they are
            end else if (pending_items.size() != 0 &&
                         $urandom_range(99) >= sender_idle_pct) begin
                start <= 1'b1;
                i_sample_value <= pending_items[0].value;
                i_last_value <= pending_items[0].last;
            end else begin
                start <= 1'b0;
                i_sample_value <= $urandom;
                i_last_value <= 1'($urandom_range(1));
            end
        end
    end

    // Monitor: compare each strobed result with the oldest prediction
    always @(posedge i_clk) begin : check_results
        t_stat_expect want;
        if (i_rst_n && o_result_strobe) begin
            if (expected_stats.size() == 0) begin
                report_mismatch($sformatf("unexpected result %h", o_stat_result));
            end else begin
                want = expected_stats.pop_front();
                if (o_stat_result !== want.stat)
                    report_mismatch($sformatf("stat_result %h, want %h",
                                              o_stat_result, want.stat));
                if (o_overflow_flag !== want.ovf)
                    report_mismatch($sformatf("overflow_flag %b, want %b",
                                              o_overflow_flag, want.ovf));
                if (o_value_count !== want.count)
                    report_mismatch($sformatf("value_count %0d, want %0d",
                                              o_value_count, want.count));
            end
        end
    end

    // Register write, only issued while the block is idle
    task automatic write_stat_mode(input logic mode);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= mode;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        predicted_mode = mode;
    endtask

    task automatic wait_drained();
        while (pending_items.size() != 0 || expected_stats.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    function automatic void push_item(input logic [VALUE_W-1:0] v, input logic last);
        t_sample_item item;
        item.value = v;
        item.last = last;
        pending_items = {pending_items, item};
    endfunction

    // Random value: extremes, small Q16.16 values, or any 32-bit pattern
    function automatic logic [VALUE_W-1:0] random_value();
        int pick;
        pick = $urandom_range(9);
        case (pick)
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'h0;
            3: return 32'($signed($urandom_range(15)) - 8);
            4, 5: return 32'($signed($urandom_range(20'hF_FFFF)) - 32'sh8_0000);
            default: return $urandom;
        endcase
    endfunction

    function automatic void push_random_set(input int len);
        logic              same_value;
        logic [VALUE_W-1:0] fixed;
        same_value = ($urandom_range(9) == 0);
        fixed = random_value();
        for (int i = 0; i < len; i++)
            push_item(same_value ? fixed : random_value(), i == len - 1);
    endfunction

    function automatic void push_directed_sets();
        push_item(32'h7FFF_FFFF, 1'b1);                 // single value
        push_item(32'h7FFF_FFFF, 1'b0);                 // both extremes
        push_item(32'h8000_0000, 1'b1);
        push_item(32'h8000_0000, 1'b0);                 // equal values
        push_item(32'h8000_0000, 1'b0);
        push_item(32'h8000_0000, 1'b1);
        push_item(-32'sd3, 1'b0);                       // mean truncates toward zero
        push_item(-32'sd4, 1'b1);
        push_item(32'h0001_0000, 1'b0);
        push_item(32'h0003_0000, 1'b0);
        push_item(32'hFFFF_0000, 1'b0);
        push_item(32'h0, 1'b1);
        push_item(32'hFFFF_FFFF, 1'b1);
    endfunction

    // Fill a phase: one set near or past the store depth, then mixed lengths
    function automatic void push_random_phase();
        int added;
        int len;
        int pick;
        len = $urandom_range(STORE_DEPTH + 6, STORE_DEPTH - 1);
        push_random_set(len);
        added = len;
        while (added < ITEMS_PER_PHASE) begin
            pick = $urandom_range(99);
            if (pick < 5) len = $urandom_range(STORE_DEPTH + 6, STORE_DEPTH - 4);
            else if (pick < 20) len = $urandom_range(2, 1);
            else len = $urandom_range(16, 3);
            push_random_set(len);
            added += len;
        end
    endfunction

    // Sequence: reset, directed sets in both modes, then random phases
    initial begin
        int idle_levels[3];
        idle_levels = '{34, 79, 0};
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        sender_idle_pct = 0;
        push_directed_sets();
        wait_drained();
        write_stat_mode(MODE_POP_STDDEV);
        push_directed_sets();
        wait_drained();

        for (int p = 0; p < 3; p++) begin
            sender_idle_pct = idle_levels[p];
            for (int m = 0; m < 2; m++) begin
                write_stat_mode((m == 0) ? MODE_SAMPLE_VAR : MODE_POP_STDDEV);
                push_random_phase();
                wait_drained();
            end
        end

        if (mismatch_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #(CLK_PERIOD * 2_000_000);
        $display("Some tests failed");
        $finish;
    end

endmodule
